### design/mxdot_pkg.sv
`default_nettype none
package mxdot_pkg;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
  localparam logic [31:0] BF_BIAS   = 32'h0000_7FFF;
  localparam logic [31:0] BF_MASK   = 32'hFFFF_0000;
  localparam logic [7:0]  SCALE_ZERO = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_ALIGN,
    ST_SHIFT,
    ST_ROUND
  } state_e;

  typedef struct packed {
    logic load;
    logic norm_en;
    logic add_en;
    logic shf_en;
    logic rnd_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  // E2M1 magnitude in units of one half.
  function automatic logic [3:0] half_units(input logic [2:0] c);
    logic [3:0] r;
    case (c)
      3'd0: r = 4'd0;
      3'd1: r = 4'd1;
      3'd2: r = 4'd2;
      3'd3: r = 4'd3;
      3'd4: r = 4'd4;
      3'd5: r = 4'd6;
      3'd6: r = 4'd8;
      3'd7: r = 4'd12;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Index of the highest set bit; zero for a zero word.
  function automatic logic [5:0] top_idx(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/mxdot_ctrl.sv
`default_nettype none
module mxdot_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire mxdot_pkg::sts_t sts_i,
  output mxdot_pkg::cmd_t      cmd_o
);

  mxdot_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic hold;

  // A finishing last beat waits while the output register is still full.
  assign hold = sts_i.last && out_valid_q && out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mxdot_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mxdot_pkg::ST_NORM;
      end
      mxdot_pkg::ST_NORM:  state_d = mxdot_pkg::ST_ALIGN;
      mxdot_pkg::ST_ALIGN: state_d = mxdot_pkg::ST_SHIFT;
      mxdot_pkg::ST_SHIFT: state_d = mxdot_pkg::ST_ROUND;
      mxdot_pkg::ST_ROUND: begin
        if (!hold) state_d = mxdot_pkg::ST_IDLE;
      end
      default: state_d = mxdot_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      mxdot_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      mxdot_pkg::ST_NORM:  cmd_o.norm_en = 1'b1;
      mxdot_pkg::ST_ALIGN: cmd_o.add_en = 1'b1;
      mxdot_pkg::ST_SHIFT: cmd_o.shf_en = 1'b1;
      mxdot_pkg::ST_ROUND: begin
        cmd_o.rnd_en = !hold;
        cmd_o.out_load = !hold && sts_i.last;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mxdot_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### design/mxdot_dp.sv
`default_nettype none
module mxdot_dp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mxdot_pkg::cmd_t cmd_i,
  input  wire logic [31:0]     activation_bits_i,
  input  wire logic [3:0]      weight_code_i,
  input  wire logic [7:0]      scale_exponent_i,
  input  wire logic            last_element_i,
  output mxdot_pkg::sts_t      sts_o,
  output logic [31:0]          dot_result_o
);

  logic [31:0] acc_q;
  logic        last_q;
  logic [31:0] res_q;

  // ---------------- decode and product ----------------
  logic [31:0] a_w;
  logic [3:0]  mw;
  logic [1:0]  tw;
  logic        sw, sa, sc, sp, w_inf, a_nan, c_nan, a_inf, c_inf, a_zero;
  logic [7:0]  ea_f, ec_f;
  logic [22:0] fa, fc;
  logic [23:0] ma, mc;
  logic signed [10:0] ea, ec, ep;
  logic        spec_w;
  logic [31:0] spec_val_w;
  logic        pz_w, cz_w;

  always_comb begin
    a_w = (activation_bits_i + mxdot_pkg::BF_BIAS + {31'b0, activation_bits_i[16]})
          & mxdot_pkg::BF_MASK;
    sw = weight_code_i[3];
    mw = (scale_exponent_i == mxdot_pkg::SCALE_ZERO) ? 4'd0
         : mxdot_pkg::half_units(weight_code_i[2:0]);
    tw = mw[3] ? 2'd3 : (mw[2] ? 2'd2 : (mw[1] ? 2'd1 : 2'd0));
    w_inf = (mw != 4'd0) && (({1'b0, scale_exponent_i} + {7'b0, tw}) >= 9'd256);
    sa = a_w[31]; ea_f = a_w[30:23]; fa = a_w[22:0];
    sc = acc_q[31]; ec_f = acc_q[30:23]; fc = acc_q[22:0];
    sp = sw ^ sa;
    a_nan = (ea_f == 8'hFF) && (fa != 23'd0);
    c_nan = (ec_f == 8'hFF) && (fc != 23'd0);
    a_inf = (ea_f == 8'hFF);
    c_inf = (ec_f == 8'hFF);
    a_zero = (ea_f == 8'd0) && (fa == 23'd0);
    ma = (ea_f == 8'd0) ? {1'b0, fa} : {1'b1, fa};
    mc = (ec_f == 8'd0) ? {1'b0, fc} : {1'b1, fc};
    ea = (ea_f == 8'd0) ? -11'sd149 : $signed({3'b000, ea_f}) - 11'sd150;
    ec = (ec_f == 8'd0) ? -11'sd149 : $signed({3'b000, ec_f}) - 11'sd150;
    ep = $signed({3'b000, scale_exponent_i}) - 11'sd128 + ea;
    pz_w = (mw == 4'd0) || (ma == 24'd0);
    cz_w = (mc == 24'd0);
    spec_w = 1'b1;
    spec_val_w = '0;
    if (a_nan || c_nan) begin
      spec_val_w = mxdot_pkg::QNAN_BITS;
    end else if (w_inf || a_inf) begin
      if (!(w_inf && a_inf) && (w_inf ? a_zero : (mw == 4'd0))) begin
        spec_val_w = mxdot_pkg::QNAN_BITS;
      end else if (c_inf && (sc != sp)) begin
        spec_val_w = mxdot_pkg::QNAN_BITS;
      end else begin
        spec_val_w = {sp, 31'b0} | mxdot_pkg::INF_BITS;
      end
    end else if (c_inf) begin
      spec_val_w = acc_q;
    end else if (pz_w && cz_w) begin
      spec_val_w = {sp && sc, 31'b0};
    end else begin
      spec_w = 1'b0;
    end
  end

  logic [27:0] mp_q;
  logic [23:0] mc_q;
  logic signed [10:0] ep_q, ec_q;
  logic sp_q, sc_q, pz_q, cz_q, spec_q;
  logic [31:0] spec_val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mp_q <= 28'(mw) * 28'(ma);
      mc_q <= mc;
      ep_q <= ep;
      ec_q <= ec;
      sp_q <= sp;
      sc_q <= sc;
      pz_q <= pz_w;
      cz_q <= cz_w;
      spec_q <= spec_w;
      spec_val_q <= spec_val_w;
    end
  end

  // ---------------- normalize to bit 62 ----------------
  logic [5:0] shp, shc_n;
  logic [63:0] mpn_q, mcn_q;
  logic signed [10:0] epn_q, ecn_q;

  always_comb begin
    shp = 6'd62 - mxdot_pkg::top_idx({36'b0, mp_q});
    shc_n = 6'd62 - mxdot_pkg::top_idx({40'b0, mc_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_en) begin
      mpn_q <= {36'b0, mp_q} << shp;
      mcn_q <= {40'b0, mc_q} << shc_n;
      epn_q <= ep_q - $signed({5'b0, shp});
      ecn_q <= ec_q - $signed({5'b0, shc_n});
    end
  end

  // ---------------- align and add ----------------
  logic sel_p, sx, sy;
  logic [63:0] mx, my, lost, msum;
  logic signed [10:0] ex, ey, d;

  always_comb begin
    if (cz_q) sel_p = 1'b1;
    else if (pz_q) sel_p = 1'b0;
    else sel_p = (epn_q > ecn_q) || ((epn_q == ecn_q) && (mpn_q >= mcn_q));
    mx = sel_p ? mpn_q : mcn_q;
    ex = sel_p ? epn_q : ecn_q;
    sx = sel_p ? sp_q : sc_q;
    my = sel_p ? mcn_q : mpn_q;
    ey = sel_p ? ecn_q : epn_q;
    sy = sel_p ? sc_q : sp_q;
    d = ex - ey;
    lost = '0;
    if (cz_q || pz_q) begin
      my = '0;
    end else if (d >= 11'sd63) begin
      my = 64'd1;
    end else if (d > 11'sd0) begin
      lost = my & ((64'd1 << d[5:0]) - 64'd1);
      my = (my >> d[5:0]) | {63'b0, lost != 64'd0};
    end
    msum = (sx == sy) ? mx + my : mx - my;
  end

  logic [63:0] m_q;
  logic signed [10:0] ex_q;
  logic sx_q, zs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en) begin
      m_q <= msum;
      ex_q <= ex;
      sx_q <= sx;
      zs_q <= (msum == 64'd0);
    end
  end

  // ---------------- rounding shift amount ----------------
  logic signed [10:0] sh, lim, shc_w;
  logic signed [10:0] sh_q, k_q;
  logic [63:0] mr_q;

  always_comb begin
    sh = $signed({5'b0, mxdot_pkg::top_idx(m_q)}) - 11'sd23;
    lim = -11'sd149 - ex_q;
    if (lim > sh) sh = lim;
    shc_w = (sh > 11'sd65) ? 11'sd65 : sh;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shf_en) begin
      sh_q <= shc_w;
      k_q <= ex_q + sh;
      mr_q <= m_q;
    end
  end

  // ---------------- shift, round and pack ----------------
  logic [127:0] t;
  logic [63:0]  ml;
  logic [23:0]  q24, qf;
  logic [24:0]  qr;
  logic         rup;
  logic signed [10:0] kf, biased, nsh;
  logic [31:0]  packed_w, result_w;

  always_comb begin
    t = '0;
    ml = '0;
    nsh = -sh_q;
    if (sh_q <= 11'sd0) begin
      ml = mr_q << nsh[4:0];
      q24 = ml[23:0];
      rup = 1'b0;
    end else begin
      t = {mr_q, 64'b0} >> sh_q[6:0];
      q24 = t[87:64];
      rup = t[63] && ((t[62:0] != 63'd0) || q24[0]);
    end
    qr = {1'b0, q24} + {24'b0, rup};
    if (qr[24]) begin
      qf = qr[24:1];
      kf = k_q + 11'sd1;
    end else begin
      qf = qr[23:0];
      kf = k_q;
    end
    biased = kf + 11'sd150;
    if (qf == 24'd0) begin
      packed_w = {sx_q, 31'b0};
    end else if (qf[23]) begin
      if (biased >= 11'sd255) packed_w = {sx_q, 31'b0} | mxdot_pkg::INF_BITS;
      else packed_w = {sx_q, biased[7:0], qf[22:0]};
    end else begin
      packed_w = {sx_q, 8'b0, qf[22:0]};
    end
    if (spec_q) result_w = spec_val_q;
    else if (zs_q) result_w = '0;
    else result_w = packed_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      last_q <= 1'b0;
    end else begin
      if (cmd_i.load) last_q <= last_element_i;
      if (cmd_i.rnd_en) acc_q <= last_q ? 32'd0 : result_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) res_q <= result_w;
  end

  assign sts_o.last = last_q;
  assign dot_result_o = res_q;

endmodule
`default_nettype wire

### design/mxfp4_bf16_fp32_dot_accumulator.sv
`default_nettype none
// Channel  | Handshake                  | Payload
// input    | in_valid_i / in_stall_o    | activation_bits_i, weight_code_i,
//          |                            | scale_exponent_i, last_element_i
// output   | out_valid_o / out_stall_i  | dot_result_o
//
// Each input beat is accepted and its product formed, then it passes through
// normalize, align and add, rounding shift setup, and final rounding.
// The running sum feeds the next product, so one beat is in flight at a time.
// Reset clears the running sum to +0 and empties the output register.
// A result waits in the output register while out_stall_i is high; the next
// row proceeds meanwhile and only its last beat waits in the rounding step.
module mxfp4_bf16_fp32_dot_accumulator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] activation_bits_i,
  input  wire logic [3:0]  weight_code_i,
  input  wire logic [7:0]  scale_exponent_i,
  input  wire logic        last_element_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      dot_result_o
);

  // Command and status buses between the sequencer and the FMA datapath.
  mxdot_pkg::cmd_t cmd;
  mxdot_pkg::sts_t sts;

  // The sequencer steps each beat through the datapath stages and owns the
  // output valid flag.
  mxdot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath dequantizes the weight, rounds the activation to bf16 and
  // performs the fused multiply-add into the running sum.
  mxdot_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .activation_bits_i (activation_bits_i),
    .weight_code_i     (weight_code_i),
    .scale_exponent_i  (scale_exponent_i),
    .last_element_i    (last_element_i),
    .sts_o             (sts),
    .dot_result_o      (dot_result_o)
  );

endmodule
`default_nettype wire
